// ===== hw/rtl/ack_retry_pending_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the acknowledgement retry table
// Shared helpers for the concurrent checks of the design.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRY_PENDING_TABLE_UNIT_MACROS_SVH
`define ACK_RETRY_PENDING_TABLE_UNIT_MACROS_SVH

// Check that is skipped while reset is applied.
`define ARPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define ARPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/arpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Acknowledgement retry table package
// Shared sizes, codes and the slot record type.
// ----------------------------------------------------------------------------
package arpt_pkg;

  localparam int SLOTS = 8;
  localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam logic [2:0] KIND_PUBLISH   = 3'd0;
  localparam logic [2:0] KIND_REPUBLISH = 3'd1;
  localparam logic [2:0] KIND_DELIVERED = 3'd2;
  localparam logic [2:0] KIND_ACKFAIL   = 3'd3;
  localparam logic [2:0] KIND_DROPPED   = 3'd4;
  localparam logic [2:0] KIND_QFULL     = 3'd5;
  localparam logic [2:0] KIND_DISABLED  = 3'd6;

  localparam logic [1:0] REG_ENABLED     = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

  localparam logic [31:0] ACK_TIMEOUT_RST = 32'd5000;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;

  typedef struct packed {
    logic        active;
    logic [15:0] id;
    logic [7:0]  pin;
    logic [31:0] value;
    logic [31:0] sent;
    logic [7:0]  retries;
  } slot_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] msg_id;
    logic [7:0]  pin;
    logic [31:0] value;
    logic [7:0]  retries;
  } res_t;

endpackage

// ===== hw/rtl/ack_retry_pending_table_unit.sv =====
// ----------------------------------------------------------------------------
// Acknowledgement retry table
// The slots sit in a ring of cells; every scanned item walks the whole ring once,
// one slot per cycle at the head while the result side does not stall it.
// A send while disabled goes straight to the finish state, and ignored
// items never leave idle. The ring step is the limit.
// ----------------------------------------------------------------------------
`include "ack_retry_pending_table_unit_macros.svh"

module ack_retry_pending_table_unit
  import arpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pin,
  input  logic [31:0] in_value,
  input  logic [15:0] in_ack_id,
  input  logic        in_ack_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_msg_id,
  output logic [7:0]  out_out_pin,
  output logic [31:0] out_out_value,
  output logic [7:0]  out_retry_count,
  output logic        out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      idc_r, idc_nxt;
  logic [31:0]      time_r, time_nxt;
  logic             en_r;
  logic [31:0]      tmo_r;
  logic [7:0]       maxr_r;
  logic [1:0]       func_r;
  logic [7:0]       pin_r;
  logic [31:0]      value_r;
  logic [15:0]      ack_id_r;
  logic             ack_ok_r;
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  slot_t ring [SLOTS];
  slot_t head_upd;
  logic  step_go, out_free, res_new, clr, accept;
  res_t  res, fin_res;

  assign clr = cfg_we && (cfg_index == REG_ENABLED) && !cfg_wdata[0];

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      slot_t d;
      if (g == SLOTS - 1) begin : g_tail
        assign d = head_upd;
      end else begin : g_mid
        assign d = ring[g+1];
      end
      arpt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (step_go),
        .clr      (clr),
        .d_in     (d),
        .q        (ring[g])
      );
    end
  endgenerate

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign step_go  = (state_r == ST_SCAN) && (!pend_v_r || out_free);

  always_comb begin
    head_upd  = ring[0];
    res_new   = 1'b0;
    res       = '0;
    found_nxt = found_r;
    idc_nxt   = idc_r;
    unique case (func_r)
      FUNC_SEND: begin
        if (!ring[0].active && !found_r) begin
          head_upd.active  = 1'b1;
          head_upd.id      = idc_r + 16'd1;
          head_upd.pin     = pin_r;
          head_upd.value   = value_r;
          head_upd.sent    = time_r;
          head_upd.retries = 8'd0;
          found_nxt        = 1'b1;
          idc_nxt          = idc_r + 16'd1;
        end
      end
      FUNC_ACK: begin
        if (ring[0].active && ring[0].id == ack_id_r && !found_r) begin
          head_upd.active = 1'b0;
          found_nxt       = 1'b1;
          res_new         = 1'b1;
          res.kind        = ack_ok_r ? KIND_DELIVERED : KIND_ACKFAIL;
          res.msg_id      = ack_id_r;
          res.retries     = ring[0].retries;
        end
      end
      FUNC_TICK: begin
        if (ring[0].active && (time_r - ring[0].sent) >= tmo_r) begin
          res_new    = 1'b1;
          res.msg_id = ring[0].id;
          if (ring[0].retries < maxr_r) begin
            head_upd.retries = ring[0].retries + 8'd1;
            head_upd.sent    = time_r;
            res.kind         = KIND_REPUBLISH;
            res.pin          = ring[0].pin;
            res.value        = ring[0].value;
            res.retries      = ring[0].retries + 8'd1;
          end else begin
            head_upd.active = 1'b0;
            res.kind        = KIND_DROPPED;
            res.retries     = ring[0].retries;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fin_res = '0;
    if (func_r == FUNC_SEND) begin
      if (!en_r) begin
        fin_res.kind = KIND_DISABLED;
      end else if (found_r) begin
        fin_res.kind   = KIND_PUBLISH;
        fin_res.msg_id = idc_r;
        fin_res.pin    = pin_r;
        fin_res.value  = value_r;
      end else begin
        fin_res.kind = KIND_QFULL;
      end
    end else begin
      fin_res = pend_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_func == FUNC_SEND && !en_r) begin
            state_nxt = ST_FIN;
          end else if (en_r && in_func != FUNC_NOP) begin
            state_nxt = ST_SCAN;
            if (in_func == FUNC_TICK) begin
              time_nxt = time_r + 32'd1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (step_go) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (res_new) begin
            if (pend_v_r) begin
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            pend_nxt   = res;
            pend_v_nxt = 1'b1;
          end
          if (cnt_r == CNT_W'(SLOTS - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (func_r != FUNC_SEND && !pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt       = fin_res;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      idc_r       <= 16'd0;
      time_r      <= 32'd0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      tmo_r       <= ACK_TIMEOUT_RST;
      maxr_r      <= MAX_RETRIES_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= accept ? 1'b0 : (step_go ? found_nxt : found_r);
      idc_r       <= step_go ? idc_nxt : idc_r;
      time_r      <= time_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLED:     en_r   <= cfg_wdata[0];
          REG_ACK_TIMEOUT: tmo_r  <= cfg_wdata;
          REG_MAX_RETRIES: maxr_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      func_r   <= in_func;
      pin_r    <= in_pin;
      value_r  <= in_value;
      ack_id_r <= in_ack_id;
      ack_ok_r <= in_ack_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_msg_id      = out_r.msg_id;
  assign out_out_pin     = out_r.pin;
  assign out_out_value   = out_r.value;
  assign out_retry_count = out_r.retries;
  assign out_last        = out_last_r;

  `ARPT_ASSERT(a_idle_no_pend, (state_r == ST_IDLE) |-> !pend_v_r,
               "Pending result left over in idle.")
  `ARPT_ASSERT(a_stall_holds, (state_r == ST_SCAN && !step_go) |=> $stable(cnt_r),
               "Ring advanced while stalled.")
  `ARPT_ASSERT(a_id_step, $rose(found_r) && (func_r == FUNC_SEND)
               |-> idc_r == $past(idc_r) + 16'd1,
               "Id counter did not advance with a slot grant.")
  `ARPT_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r,
                      "Reset did not return to idle.")

endmodule

// ===== hw/rtl/arpt_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one table slot and passes it to its neighbor on each ring step.
// ----------------------------------------------------------------------------
module arpt_cell
  import arpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  logic  clr,
  input  slot_t d_in,
  output slot_t q
);

  logic  active_r;
  slot_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      active_r <= 1'b0;
    end else if (shift_en) begin
      active_r <= d_in.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  always_comb begin
    q        = data_r;
    q.active = active_r;
  end

endmodule
